[rtl/nszc_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest sphere zone check package
// Shared types, widths and constants for the hazard zone checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nszc_pkg;

    localparam int COORD_W     = 24;
    localparam int RAD_W       = 23;
    localparam int HOR_W       = 16;
    localparam int ZIDX_W      = 4;
    localparam int ABS_W       = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int D2_W        = SQ_W + 1;
    localparam int R2_W        = 2 * RAD_W;
    localparam int ROOT_W      = RAD_W;
    localparam int SPEED_W     = 35;
    localparam int SPEED_SHIFT = 7;

    localparam int DEF_NUM_ZONES = 16;

    localparam logic [11:0]     SPEED_NUM = 12'd3125;
    localparam logic [RAD_W-1:0] DIST_NONE = {RAD_W{1'b1}};
    localparam logic [HOR_W-1:0] TTI_NONE  = {HOR_W{1'b1}};

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [RAD_W-1:0]          radius;
        logic [HOR_W-1:0]          horizon_ms;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic              hit;
        logic [ZIDX_W-1:0] zone_index;
        logic [RAD_W-1:0]  distance;
        logic [HOR_W-1:0]  tti_ms;
        logic              tti_infinite;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [RAD_W-1:0]          r;
    } zone_t;

    typedef struct packed {
        logic            pending;
        logic            found;
        logic [D2_W-1:0] best_d2;
    } scan_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ROOT,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

[rtl/nszc_zone_mem.sv]
// ----------------------------------------------------------------------------
// Zone table memory
// One-port-write, one-port-read synchronous store of zone centres and radii.
// ----------------------------------------------------------------------------
`default_nettype none

module nszc_zone_mem
    import nszc_pkg::*;
#(
    parameter int NUM_ZONES = DEF_NUM_ZONES,
    parameter int IDX_W     = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire zone_t            wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output zone_t                 rd_data
);

    zone_t mem [NUM_ZONES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/nszc_scan.sv]
// ----------------------------------------------------------------------------
// Zone scan pipeline
// Squared distance per zone and running choice of the nearest containing one.
// ----------------------------------------------------------------------------
`default_nettype none

module nszc_scan
    import nszc_pkg::*;
#(
    parameter int NUM_ZONES = DEF_NUM_ZONES,
    parameter int IDX_W     = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      clear,
    input  wire logic                      issue,
    input  wire logic [IDX_W-1:0]          issue_idx,
    input  wire logic signed [COORD_W-1:0] pt_x,
    input  wire logic signed [COORD_W-1:0] pt_y,
    input  wire logic signed [COORD_W-1:0] pt_z,
    input  wire zone_t                     zone,
    output scan_status_t                   status,
    output logic [IDX_W-1:0]               best_idx
);

    // Stage valid flags.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;

    logic [ABS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [RAD_W-1:0] r2s_reg;
    logic [SQ_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [R2_W-1:0]  r2_reg, r2b_reg;
    logic [D2_W-1:0]  d2_reg;

    logic             found_reg, found_next;
    logic [D2_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;

    logic signed [ABS_W-1:0] dx, dy, dz;
    logic [2*ABS_W-1:0]      px2, py2, pz2;
    logic                    contained, nearer;

    always_comb
    begin
        dx = ABS_W'(pt_x) - ABS_W'(zone.x);
        dy = ABS_W'(pt_y) - ABS_W'(zone.y);
        dz = ABS_W'(pt_z) - ABS_W'(zone.z);
        px2 = ax_reg * ax_reg;
        py2 = ay_reg * ay_reg;
        pz2 = az_reg * az_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= issue_idx;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        ax_reg   <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        ay_reg   <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
        az_reg   <= dz[ABS_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
        r2s_reg  <= zone.r;
        sx_reg   <= px2[SQ_W-1:0];
        sy_reg   <= py2[SQ_W-1:0];
        sz_reg   <= pz2[SQ_W-1:0];
        r2_reg   <= R2_W'(r2s_reg) * R2_W'(r2s_reg);
        d2_reg   <= D2_W'(sx_reg) + D2_W'(sy_reg) + D2_W'(sz_reg);
        r2b_reg  <= r2_reg;
    end

    // Strictly inside, and strictly nearer so the earlier zone keeps a tie.
    always_comb
    begin
        contained     = d2_reg < D2_W'(r2b_reg);
        nearer        = !found_reg || (d2_reg < best_reg);
        found_next    = found_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (v4_reg && contained && nearer)
        begin
            found_next    = 1'b1;
            best_next     = d2_reg;
            best_idx_next = idx4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

    assign status.pending = v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.found   = found_reg;
    assign status.best_d2 = best_reg;
    assign best_idx       = best_idx_reg;

endmodule

`default_nettype wire

[rtl/nszc_isqrt.sv]
// ----------------------------------------------------------------------------
// Integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nszc_isqrt
    import nszc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [R2_W-1:0]   radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 4;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [R2_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] res_reg, res_next;

    logic [REM_W-1:0] rem_shift, trial;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[R2_W-1 -: 2]};
        trial     = {2'b00, res_reg, 2'b01};
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = STEP_W'(ROOT_W - 1);
            rad_next  = radicand;
            rem_next  = '0;
            res_next  = '0;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[R2_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next = rem_shift - trial;
                res_next = {res_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                res_next = {res_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

`default_nettype wire

[rtl/nearest_sphere_zone_check.sv]
// ----------------------------------------------------------------------------
// Nearest sphere zone check
// Table of spherical hazard zones with add and nearest-containing-zone check.
// ----------------------------------------------------------------------------
// A command word is taken on cmd at a rising edge where start is high and busy
// is low. An add word appends a zone to the table at the next free entry, or
// reports status full when the table holds NUM_ZONES zones already. A check
// word walks every stored zone and reports the nearest zone that strictly
// contains the point, its integer distance and the time to impact.
// Each command yields one result word on result, marked by done for exactly
// one cycle; the receiver cannot stall, so the word must be taken then.
// An add answers in the cycle after acceptance and leaves busy low.
// A check reads one zone per cycle from the zone memory and then runs the
// bit-serial square root on the nearest squared distance. A check that
// finds no containing zone skips the root.
// Reset empties the table (the zone count returns to zero) and idles the
// controller; the zone memory itself is not cleared, since only entries
// below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_sphere_zone_check
    import nszc_pkg::*;
#(
    parameter int NUM_ZONES = DEF_NUM_ZONES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t cmd,
    output logic      busy,
    output logic      done,
    output result_t   result
);

    localparam int IDX_W = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam int CNT_W = $clog2(NUM_ZONES + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] walk_reg, walk_next;
    logic             done_reg, done_next;
    result_t          result_reg, result_next;

    // Latched point and horizon of the check in progress.
    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [HOR_W-1:0]          hor_reg;

    logic accept, room, more;
    logic wr_en, rd_en, scan_clear, root_start, load_point;

    zone_t            wr_zone, rd_zone;
    scan_status_t     scan;
    logic [IDX_W-1:0] best_idx;
    logic             root_done;
    logic [ROOT_W-1:0] root;

    logic [SPEED_W-1:0] speed_lhs, speed_rhs;
    logic               slow;

    assign accept = start && !busy;
    assign room   = count_reg < CNT_W'(NUM_ZONES);
    assign more   = walk_reg < count_reg;

    assign wr_zone.x = cmd.pos_x;
    assign wr_zone.y = cmd.pos_y;
    assign wr_zone.z = cmd.pos_z;
    assign wr_zone.r = cmd.radius;

    // Adds and checks never overlap in time, so a read can never meet a
    // write to the same entry: the walk starts only after the add has landed.
    nszc_zone_mem #(
        .NUM_ZONES (NUM_ZONES),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_zone),
        .rd_en   (rd_en),
        .rd_addr (walk_reg[IDX_W-1:0]),
        .rd_data (rd_zone)
    );

    nszc_scan #(
        .NUM_ZONES (NUM_ZONES),
        .IDX_W     (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .issue     (rd_en),
        .issue_idx (walk_reg[IDX_W-1:0]),
        .pt_x      (pt_x_reg),
        .pt_y      (pt_y_reg),
        .pt_z      (pt_z_reg),
        .zone      (rd_zone),
        .status    (scan),
        .best_idx  (best_idx)
    );

    nszc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (scan.best_d2[R2_W-1:0]),
        .done     (root_done),
        .root     (root)
    );

    // Speed below 0.01 m/s is the same as 3125 * D < 128 * H.
    assign speed_lhs = SPEED_W'(SPEED_NUM) * SPEED_W'(root);
    assign speed_rhs = SPEED_W'(hor_reg) << SPEED_SHIFT;
    assign slow      = speed_lhs < speed_rhs;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.action == ACT_CHECK))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!more && !scan.pending)
                begin
                    state_next = scan.found ? ST_ROOT : ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b1;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        scan_clear  = 1'b0;
        root_start  = 1'b0;
        load_point  = 1'b0;
        count_next  = count_reg;
        walk_next   = walk_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (accept)
                begin
                    if (cmd.action == ACT_ADD)
                    begin
                        wr_en                  = room;
                        count_next             = room ? count_reg + 1'b1 : count_reg;
                        done_next              = 1'b1;
                        result_next            = '0;
                        result_next.status     = room ? STATUS_OK : STATUS_FULL;
                    end
                    else
                    begin
                        load_point = 1'b1;
                        scan_clear = 1'b1;
                        walk_next  = '0;
                    end
                end
            end
            ST_WALK:
            begin
                if (more)
                begin
                    rd_en     = 1'b1;
                    walk_next = walk_reg + 1'b1;
                end
                else if (!scan.pending)
                begin
                    if (scan.found)
                    begin
                        root_start = 1'b1;
                    end
                    else
                    begin
                        done_next                = 1'b1;
                        result_next.status       = STATUS_OK;
                        result_next.hit          = 1'b0;
                        result_next.zone_index   = '0;
                        result_next.distance     = DIST_NONE;
                        result_next.tti_ms       = TTI_NONE;
                        result_next.tti_infinite = 1'b1;
                    end
                end
            end
            ST_ROOT:
            begin
            end
            ST_FIN:
            begin
                done_next                = 1'b1;
                result_next.status       = STATUS_OK;
                result_next.hit          = 1'b1;
                result_next.zone_index   = ZIDX_W'(best_idx);
                result_next.distance     = root;
                result_next.tti_ms       = slow ? TTI_NONE : hor_reg;
                result_next.tti_infinite = slow;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            walk_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (load_point)
        begin
            pt_x_reg <= cmd.pos_x;
            pt_y_reg <= cmd.pos_y;
            pt_z_reg <= cmd.pos_z;
            hor_reg  <= cmd.horizon_ms;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[tb/nearest_sphere_zone_check_test.sv]
// ----------------------------------------------------------------------------
// Nearest sphere zone check testbench
// Self-checking test of the hazard zone table: a walked table of directed
// words, then a random mix of adds and checks. Every result word is compared
// field by field with a fixed answer from the plan or with the answer worked
// out by a behavioural copy of the zone table kept inside this testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_sphere_zone_check_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nszc_pkg::*;

    localparam int NZ           = DEF_NUM_ZONES;
    localparam int RANDOM_WORDS = 1000;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 64;

    // Answers that can be read straight off the behaviour of the block.
    localparam result_t ADD_OK   = '{STATUS_OK, 1'b0, '0, '0, '0, 1'b0};
    localparam result_t ADD_FULL = '{STATUS_FULL, 1'b0, '0, '0, '0, 1'b0};
    localparam result_t NO_HIT   = '{STATUS_OK, 1'b0, '0, DIST_NONE, TTI_NONE, 1'b1};

    // One row of the directed plan. A row may be repeated, and a scattered
    // row gets fresh random coordinates and radius on every repeat.
    typedef struct {
        cmd_t    word;
        int      reps;
        bit      scatter;
        bit      typed;
        result_t answer;
    } plan_row_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    // The testbench's own copy of the zone table.
    logic signed [COORD_W-1:0] zone_x [NZ];
    logic signed [COORD_W-1:0] zone_y [NZ];
    logic signed [COORD_W-1:0] zone_z [NZ];
    logic [RAD_W-1:0]          zone_r [NZ];
    int                        zone_total = 0;

    result_t   pending_answers [$];
    plan_row_t plan [$];
    int        fails  = 0;
    int        cycles = 0;
    int        calm   = 0;

    nearest_sphere_zone_check #(
        .NUM_ZONES(NZ)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Every mismatch goes through here: one line each, and all are counted.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fails++;
    endtask

    task automatic compare_word(input result_t want, input result_t got);
        if (got.status !== want.status)
        begin
            report_mismatch($sformatf("status expected %0d got %0d", want.status, got.status));
        end
        if (got.hit !== want.hit)
        begin
            report_mismatch($sformatf("hit expected %0d got %0d", want.hit, got.hit));
        end
        if (got.zone_index !== want.zone_index)
        begin
            report_mismatch($sformatf("zone_index expected %0d got %0d",
                                      want.zone_index, got.zone_index));
        end
        if (got.distance !== want.distance)
        begin
            report_mismatch($sformatf("distance expected %0d got %0d",
                                      want.distance, got.distance));
        end
        if (got.tti_ms !== want.tti_ms)
        begin
            report_mismatch($sformatf("tti_ms expected %0d got %0d", want.tti_ms, got.tti_ms));
        end
        if (got.tti_infinite !== want.tti_infinite)
        begin
            report_mismatch($sformatf("tti_infinite expected %0d got %0d",
                                      want.tti_infinite, got.tti_infinite));
        end
    endtask

    // Floor square root, found one bit at a time from the top: a bit is kept
    // when the square of the trial root still fits under the value.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Applies one accepted word to the table copy and works out the result
    // word that it must produce.
    function automatic result_t zone_answer(input cmd_t w);
        result_t     a;
        longint      dx;
        longint      dy;
        longint      dz;
        longint      d2;
        longint      r2;
        longint      best_d2;
        bit          found;
        int          best_i;
        logic [63:0] root;
        a = ADD_OK;
        if (w.action == ACT_ADD)
        begin
            if (zone_total < NZ)
            begin
                zone_x[zone_total] = w.pos_x;
                zone_y[zone_total] = w.pos_y;
                zone_z[zone_total] = w.pos_z;
                zone_r[zone_total] = w.radius;
                zone_total++;
            end
            else
            begin
                a = ADD_FULL;
            end
            return a;
        end
        found   = 1'b0;
        best_d2 = 0;
        best_i  = 0;
        for (int i = 0; i < zone_total; i++)
        begin
            dx = longint'($signed(w.pos_x)) - longint'($signed(zone_x[i]));
            dy = longint'($signed(w.pos_y)) - longint'($signed(zone_y[i]));
            dz = longint'($signed(w.pos_z)) - longint'($signed(zone_z[i]));
            d2 = dx * dx + dy * dy + dz * dz;
            r2 = longint'(zone_r[i]) * longint'(zone_r[i]);
            // Strictly inside only; on a tie the earlier zone is kept.
            if (d2 < r2 && (!found || d2 < best_d2))
            begin
                found   = 1'b1;
                best_d2 = d2;
                best_i  = i;
            end
        end
        if (!found)
        begin
            return NO_HIT;
        end
        root         = floor_root(64'(best_d2));
        a.status     = STATUS_OK;
        a.hit        = 1'b1;
        a.zone_index = best_i[ZIDX_W-1:0];
        a.distance   = root[RAD_W-1:0];
        // The implied speed is below 0.01 m/s exactly when
        // 3125 * distance < 128 * horizon.
        if (64'(SPEED_NUM) * root < (64'(w.horizon_ms) << SPEED_SHIFT))
        begin
            a.tti_ms       = TTI_NONE;
            a.tti_infinite = 1'b1;
        end
        else
        begin
            a.tti_ms       = w.horizon_ms;
            a.tti_infinite = 1'b0;
        end
        return a;
    endfunction

    function automatic cmd_t make_word(input logic act,
                                       input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic signed [COORD_W-1:0] z,
                                       input logic [RAD_W-1:0] r,
                                       input logic [HOR_W-1:0] h);
        cmd_t w;
        w.action     = act;
        w.pos_x      = x;
        w.pos_y      = y;
        w.pos_z      = z;
        w.radius     = r;
        w.horizon_ms = h;
        return w;
    endfunction

    // Horizons are mostly uniform, with the edges of the field now and then.
    function automatic logic [HOR_W-1:0] random_horizon();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return HOR_W'(1);
        end
        if (pick == 2)
        begin
            return TTI_NONE;
        end
        return HOR_W'($urandom());
    endfunction

    // A check word aimed at a stored zone: either a few units from its
    // centre, which exercises the infinite time to impact, or anywhere in a
    // box of half the radius, which lands inside the sphere.
    function automatic cmd_t near_word(input bit tight);
        int i;
        int spread;
        int ox;
        int oy;
        int oz;
        i      = $urandom_range(0, zone_total - 1);
        spread = tight ? 40 : int'(zone_r[i] / 2);
        ox     = int'($urandom_range(0, 2 * spread)) - spread;
        oy     = int'($urandom_range(0, 2 * spread)) - spread;
        oz     = int'($urandom_range(0, 2 * spread)) - spread;
        return make_word(ACT_CHECK, zone_x[i] + COORD_W'(ox), zone_y[i] + COORD_W'(oy),
                         zone_z[i] + COORD_W'(oz), RAD_W'($urandom()), random_horizon());
    endfunction

    // Idle cycles before the next word. Most gaps are short, a few are long
    // enough to land anywhere in a full check, and now and then a calm
    // stretch sends words back to back.
    function automatic int pick_gap();
        int pick;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 50)
        begin
            return 0;
        end
        if (pick < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 70);
    endfunction

    // Offers one word and waits for the block to take it. Start stays high
    // across back-to-back words; it is lowered only for a real gap. Busy is
    // read just after the edge, so it is the value the block saw there.
    task automatic send_word(input cmd_t w, input bit typed, input result_t answer);
        int      gap;
        result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        // The word was taken at this edge: update the table copy at once.
        predicted = zone_answer(w);
        pending_answers.insert(pending_answers.size(), typed ? answer : predicted);
    endtask

    task automatic plan_row(input cmd_t w, input int reps, input bit scatter,
                            input bit typed, input result_t answer);
        plan_row_t row;
        row.word    = w;
        row.reps    = reps;
        row.scatter = scatter;
        row.typed   = typed;
        row.answer  = answer;
        plan.insert(plan.size(), row);
    endtask

    // Result side: the block cannot be held off, so every strobed word is
    // taken at the edge that ends its cycle and matched with the oldest
    // answer still waiting.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("result word with no answer waiting");
            end
            else
            begin
                compare_word(pending_answers.pop_front(), result);
            end
        end
    end

    // A hung block must not stall the run for ever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        cmd_t w;
        int   sel;

        // Directed plan. Zones 0 and 2 are the same sphere round the origin,
        // zone 1 has no radius at all, zones 3 and 4 sit in the far corners
        // with the largest radius, and zone 5 lies close to zone 0.
        plan_row(make_word(ACT_CHECK, 0, 0, 0, 0, 1000), 1, 0, 1, NO_HIT);
        plan_row(make_word(ACT_ADD, 0, 0, 0, 40960, 0), 1, 0, 1, ADD_OK);
        // Zero horizon: the speed test is never met, so the horizon itself
        // comes back.
        plan_row(make_word(ACT_CHECK, 0, 0, 0, 0, 0), 1, 0, 1,
                 '{STATUS_OK, 1'b1, '0, '0, '0, 1'b0});
        // A point on the surface is not inside.
        plan_row(make_word(ACT_CHECK, 40960, 0, 0, 0, 1000), 1, 0, 1, NO_HIT);
        plan_row(make_word(ACT_CHECK, 40959, 0, 0, 0, 1000), 1, 0, 0, NO_HIT);
        // Either side of the speed threshold, distance 128 against 127.
        plan_row(make_word(ACT_CHECK, 128, 0, 0, 0, 3125), 1, 0, 0, NO_HIT);
        plan_row(make_word(ACT_CHECK, 0, 127, 0, 0, 3125), 1, 0, 0, NO_HIT);
        plan_row(make_word(ACT_CHECK, 0, 0, 0, 0, 16'hFFFF), 1, 0, 1,
                 '{STATUS_OK, 1'b1, '0, '0, TTI_NONE, 1'b1});
        plan_row(make_word(ACT_ADD, 1000, 0, 0, 0, 0), 1, 0, 1, ADD_OK);
        plan_row(make_word(ACT_CHECK, 1000, 0, 0, 0, 500), 1, 0, 0, NO_HIT);
        plan_row(make_word(ACT_ADD, 0, 0, 0, 40960, 0), 1, 0, 1, ADD_OK);
        plan_row(make_word(ACT_CHECK, 5, -5, 5, 0, 1), 1, 0, 0, NO_HIT);
        plan_row(make_word(ACT_ADD, 8388607, 8388607, 8388607, 8388607, 16'hFFFF),
                 1, 0, 1, ADD_OK);
        plan_row(make_word(ACT_ADD, -8388608, -8388608, -8388608, 8388607, 16'hFFFF),
                 1, 0, 1, ADD_OK);
        plan_row(make_word(ACT_CHECK, 8388607, 8388607, 8388607, 8388607, 16'hFFFF),
                 1, 0, 1, '{STATUS_OK, 1'b1, ZIDX_W'(3), '0, TTI_NONE, 1'b1});
        plan_row(make_word(ACT_CHECK, -8388608, -8388608, -8388608, 0, 16'hFFFF),
                 1, 0, 1, '{STATUS_OK, 1'b1, ZIDX_W'(4), '0, TTI_NONE, 1'b1});
        plan_row(make_word(ACT_CHECK, 8388607, -8388608, 0, 0, 16'hFFFF), 1, 0, 0, NO_HIT);
        plan_row(make_word(ACT_ADD, 4096, 0, 0, 8192, 0), 1, 0, 1, ADD_OK);
        // Inside zones 0, 2 and 5; zone 5 is the nearest.
        plan_row(make_word(ACT_CHECK, 4000, 0, -3, 0, 2000), 1, 0, 0, NO_HIT);
        // Fill the rest of the table with scattered zones, then one more add
        // must be refused with the table full.
        plan_row(make_word(ACT_ADD, 0, 0, 0, 0, 0), NZ - 6, 1, 1, ADD_OK);
        plan_row(make_word(ACT_ADD, -1, -1, -1, 8388607, 16'hFFFF), 1, 0, 1, ADD_FULL);
        plan_row(make_word(ACT_CHECK, 4096, 0, 0, 0, 7), 1, 0, 0, NO_HIT);

        // Reset is held from time zero and released on an edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[p])
        begin
            for (int k = 0; k < plan[p].reps; k++)
            begin
                w = plan[p].word;
                if (plan[p].scatter)
                begin
                    w.pos_x = COORD_W'($urandom());
                    w.pos_y = COORD_W'($urandom());
                    w.pos_z = COORD_W'($urandom());
                    // Half the scattered zones are huge, so that random
                    // points hit them often.
                    w.radius = ($urandom_range(0, 1) == 0) ? RAD_W'($urandom())
                                                           : RAD_W'($urandom_range(0, 1 << 20));
                end
                send_word(w, plan[p].typed, plan[p].answer);
            end
        end

        // Random part. The table is full from here on, so adds only check the
        // refusal; most words are checks aimed at stored zones, the rest are
        // points anywhere in space.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                w = make_word(ACT_ADD, COORD_W'($urandom()), COORD_W'($urandom()),
                              COORD_W'($urandom()), RAD_W'($urandom()), HOR_W'($urandom()));
            end
            else if (sel < 35)
            begin
                w = near_word(1'b1);
            end
            else if (sel < 75)
            begin
                w = near_word(1'b0);
            end
            else
            begin
                w = make_word(ACT_CHECK, COORD_W'($urandom()), COORD_W'($urandom()),
                              COORD_W'($urandom()), RAD_W'($urandom()), random_horizon());
            end
            send_word(w, 1'b0, NO_HIT);
        end
        start <= 1'b0;

        // Let the last answers drain, then allow a full check's worth of
        // cycles for any stray result word to show itself.
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        if (fails == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
